[design/dual_channel_fir_lowpass_assert.svh]
// Assertion helpers used by the checker file.
`ifndef DUAL_CHANNEL_FIR_LOWPASS_ASSERT_SVH
`define DUAL_CHANNEL_FIR_LOWPASS_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DCFL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcfl check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DCFL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcfl check failed");

`endif

[design/dcfl_pkg.sv]
package dcfl_pkg;

    localparam int DEF_TAP_COUNT   = 51;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int COEF_TABLE_LEN  = 51;
    localparam int COEF_BITS       = 16;
    localparam int COEF_FRAC_BITS  = 15;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    // Q1.15 low-pass taps, symmetric, summing to 32768 (unity DC gain)
    localparam t_coef COEF_TABLE [COEF_TABLE_LEN] = '{
        16'sd0,    16'sd5,    16'sd13,   16'sd23,   16'sd39,
        16'sd61,   16'sd91,   16'sd131,  16'sd180,  16'sd240,
        16'sd312,  16'sd393,  16'sd485,  16'sd585,  16'sd691,
        16'sd801,  16'sd914,  16'sd1025, 16'sd1133, 16'sd1234,
        16'sd1325, 16'sd1403, 16'sd1467, 16'sd1514, 16'sd1543,
        16'sd1552, 16'sd1543, 16'sd1514, 16'sd1467, 16'sd1403,
        16'sd1325, 16'sd1234, 16'sd1133, 16'sd1025, 16'sd914,
        16'sd801,  16'sd691,  16'sd585,  16'sd485,  16'sd393,
        16'sd312,  16'sd240,  16'sd180,  16'sd131,  16'sd91,
        16'sd61,   16'sd39,   16'sd23,   16'sd13,   16'sd5,
        16'sd0
    };

    // Taps beyond the table weigh zero
    function automatic t_coef coef_at(input int unsigned idx);
        t_coef c;
        c = '0;
        if (idx < COEF_TABLE_LEN) begin
            c = COEF_TABLE[idx];
        end
        return c;
    endfunction

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

endpackage

[design/dcfl_mac.sv]
module dcfl_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  dcfl_pkg::t_mac_ctrl           i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  dcfl_pkg::t_coef               i_coef,
    output logic signed [SAMPLE_BITS-1:0] o_result
);
    import dcfl_pkg::*;

    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int AW   = PW + 1;
    localparam int MAXI = (1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam int MINI = -(1 <<< (SAMPLE_BITS - 1));
    localparam int HALF = 1 <<< (COEF_FRAC_BITS - 1);

    localparam logic signed [AW-1:0] SAT_MAX = AW'(MAXI);
    localparam logic signed [AW-1:0] SAT_MIN = AW'(MINI);
    localparam logic signed [AW-1:0] RND     = AW'(HALF);

    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] w_sum;
    logic signed [AW-1:0] w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_sample * i_coef;
        end
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    // round half up, then clamp
    always_comb begin
        w_sum = r_acc + RND;
        w_rnd = w_sum >>> COEF_FRAC_BITS;
        if (w_rnd > SAT_MAX) begin
            o_result = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (w_rnd < SAT_MIN) begin
            o_result = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_result = w_rnd[SAMPLE_BITS-1:0];
        end
    end

endmodule

[design/dual_channel_fir_lowpass.sv]
// Dual-channel low-pass FIR: each input transfer carries one red and one infrared sample;
// both are written side by side into one circular sample memory (TAP_COUNT entries), and
// then every tap is read back, newest first, one entry a cycle, feeding two registered
// multiply-accumulate units (one per channel) with the symmetric Q1.15 coefficients.
// The sums are rounded half up and saturated to signed SAMPLE_BITS. Each item passes through
// an accept, TAP_COUNT reads through the single read port of the sample memory, a drain of
// the read/multiply/accumulate pipeline and the load of the result, before the next input
// transfer can be taken; the load waits for a free output register.
// One item is worked on at a time; a finished result sits in the output register, so the
// next item may be taken while it waits. After reset the delay lines read as zero: a fill
// count masks taps not yet written, so no clearing pass is needed.
module dual_channel_fir_lowpass #(
    parameter int TAP_COUNT   = dcfl_pkg::DEF_TAP_COUNT,
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_red,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ir,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_red,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_ir
);
    import dcfl_pkg::*;

    localparam int KW = $clog2(TAP_COUNT);
    localparam int FW = $clog2(TAP_COUNT + 1);
    localparam logic [KW-1:0] LAST_K = KW'(TAP_COUNT - 1);
    localparam logic [FW-1:0] FULL   = FW'(TAP_COUNT);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    // sample memory: red in the upper half, infrared in the lower
    logic [2*SAMPLE_BITS-1:0] mem [TAP_COUNT];
    logic [2*SAMPLE_BITS-1:0] r_rd;

    logic [KW-1:0] r_wp;     // next write slot
    logic [KW-1:0] r_rp;     // slot being read
    logic [KW-1:0] r_k;      // tap being read
    logic [KW-1:0] r_k1;     // tap of the data in r_rd
    logic [FW-1:0] r_fill;   // samples written since reset, capped
    logic          r_v1;     // r_rd holds a tap
    logic          r_v2;     // products hold a tap

    logic          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_red;
    logic signed [SAMPLE_BITS-1:0] r_out_ir;

    logic          w_accept;
    logic          w_load;
    t_coef         w_coef;
    t_mac_ctrl     w_ctrl;
    logic [2*SAMPLE_BITS-1:0] w_rd;
    logic signed [SAMPLE_BITS-1:0] w_res_red;
    logic signed [SAMPLE_BITS-1:0] w_res_ir;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // result complete once the pipeline has emptied; wait for a free output register
    assign w_load   = (r_state == S_DRAIN) && !r_v1 && !r_v2 && (!r_out_valid || i_ready);

    // taps not yet written since reset feed zero samples
    always_comb begin
        w_coef = coef_at(32'(r_k1));
        w_rd   = '0;
        if (FW'(r_k1) < r_fill) begin
            w_rd = r_rd;
        end
        w_ctrl.clr    = w_accept;
        w_ctrl.mul_en = r_v1;
        w_ctrl.acc_en = r_v2;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_k == LAST_K) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory: write on input transfer, read one slot every cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem[r_wp] <= {i_sample_red, i_sample_ir};
        end
        r_rd <= mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_k         <= '0;
            r_k1        <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_RUN);
            r_v2    <= r_v1;
            r_k1    <= r_k;
            if (w_accept) begin
                // start reading at the slot just written: tap 0 is the newest sample
                r_rp <= r_wp;
                r_k  <= '0;
                r_wp <= (r_wp == LAST_K) ? '0 : r_wp + 1'b1;
                if (r_fill != FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (r_state == S_RUN) begin
                // step back through the ring towards older samples
                r_rp <= (r_rp == '0) ? LAST_K : r_rp - 1'b1;
                r_k  <= r_k + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_red <= w_res_red;
            r_out_ir  <= w_res_ir;
        end
    end

    dcfl_mac #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mac_red (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_sample(w_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_coef  (w_coef),
        .o_result(w_res_red)
    );

    dcfl_mac #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mac_ir (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_sample(w_rd[SAMPLE_BITS-1:0]),
        .i_coef  (w_coef),
        .o_result(w_res_ir)
    );

    assign o_valid        = r_out_valid;
    assign o_filtered_red = r_out_red;
    assign o_filtered_ir  = r_out_ir;

endmodule

[design/dcfl_checker.sv]
`include "dual_channel_fir_lowpass_assert.svh"

module dcfl_checker #(
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [SAMPLE_BITS-1:0] o_filtered_red,
    input logic [SAMPLE_BITS-1:0] o_filtered_ir
);

    // one item at a time: busy straight after an input transfer
    `DCFL_ASSERT_NEXT(a_busy_after_in, i_valid && o_ready, !o_ready)

    // no result appears in the cycle after an input transfer
    `DCFL_ASSERT_NEXT(a_no_early_out, i_valid && o_ready, !$rose(o_valid))

    // a new result is only loaded while the block is busy
    `DCFL_ASSERT_NOW(a_out_from_busy, $rose(o_valid), !$past(o_ready))

    // stalled result holds
    `DCFL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_filtered_red) && $stable(o_filtered_ir))

endmodule

bind dual_channel_fir_lowpass dcfl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dcfl_checker (.*);

[test/tb_dual_channel_fir_lowpass.sv]
`timescale 1ns / 100ps

module tb_dual_channel_fir_lowpass;

    import dcfl_pkg::*;

    localparam int TAPS  = DEF_TAP_COUNT;
    localparam int SBITS = DEF_SAMPLE_BITS;
    localparam int FRAC  = 15;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SBITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // Low-pass weights in Q1.15, newest tap first; symmetric, summing to 32768
    localparam int TAP_WEIGHT [TAPS] = '{
        0,    5,    13,   23,   39,   61,   91,   131,  180,  240,
        312,  393,  485,  585,  691,  801,  914,  1025, 1133, 1234,
        1325, 1403, 1467, 1514, 1543, 1552, 1543, 1514, 1467, 1403,
        1325, 1234, 1133, 1025, 914,  801,  691,  585,  485,  393,
        312,  240,  180,  131,  91,   61,   39,   23,   13,   5,
        0
    };

    typedef logic signed [SBITS-1:0] t_sample;

    typedef struct packed {
        t_sample red;
        t_sample ir;
    } t_filtered_pair;

    // One row of the opening sequence: a sample pair sent reps times in a row.
    // Where known is set, the last transfer of the row is checked against the
    // values typed here rather than against the running filter.
    typedef struct packed {
        t_sample        red;
        t_sample        ir;
        logic [7:0]     reps;
        logic           known;
        t_filtered_pair want;
    } t_plan_row;

    typedef enum int {
        SEG_NOISE,
        SEG_HOLD,
        SEG_IMPULSE,
        SEG_WOBBLE,
        SEG_SQUARE
    } t_seg_kind;

    localparam int PLAN_ROWS = 9;

    localparam t_plan_row OPENING_PLAN [PLAN_ROWS] = '{
        // first transfer after reset lands on tap 0, which weighs nothing
        '{16'sh4000, 16'shC000, 8'd1,  1'b1, '{16'sh0000, 16'sh0000}},
        // previous sample now on tap 1 (weight 5): +2.5 rounds to 3, -2.5 to -2
        '{16'sh8000, 16'sh7FFF, 8'd1,  1'b1, '{16'sd3, -16'sd2}},
        // full scale held on every weighted tap: range minimum and maximum
        '{16'sh8000, 16'sh7FFF, 8'd49, 1'b1, '{16'sh8000, 16'sh7FFF}},
        '{16'sh7FFF, 16'sh8000, 8'd50, 1'b1, '{16'sh7FFF, 16'sh8000}},
        // flush back to silence
        '{16'sh0000, 16'sh0000, 8'd50, 1'b1, '{16'sh0000, 16'sh0000}},
        // unit impulse of opposite sign per channel, then let it walk the taps
        '{16'sh0001, 16'shFFFF, 8'd1,  1'b0, '0},
        '{16'sh0000, 16'sh0000, 8'd12, 1'b0, '0},
        // alternating bit patterns
        '{16'sh5555, 16'shAAAA, 8'd3,  1'b0, '0},
        '{16'shAAAA, 16'sh5555, 8'd3,  1'b0, '0}
    };

    localparam int RANDOM_ITEMS = 480;
    localparam int PAUSE_EVERY  = 160;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_sample i_sample_red;
    t_sample i_sample_ir;
    logic    o_valid;
    logic    i_ready;
    t_sample o_filtered_red;
    t_sample o_filtered_ir;

    // Shared by both sides: clear it for stretches with no idling at all
    bit idle_on = 1'b1;

    int mismatch_count = 0;

    // Our own copy of both delay lines, index 0 red, index 1 infrared
    t_sample tap_line [2][TAPS];

    t_filtered_pair pending_filtered [$];

    dual_channel_fir_lowpass #(
        .TAP_COUNT  (TAPS),
        .SAMPLE_BITS(SBITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_red  (i_sample_red),
        .i_sample_ir   (i_sample_ir),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_filtered_red(o_filtered_red),
        .o_filtered_ir (o_filtered_ir)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shift one sample into a channel's line, take the weighted sum exactly,
    // round half up and clamp to the sample range.
    function automatic t_sample lowpass_step(input int ch, input t_sample x);
        longint acc;
        longint rounded;
        acc = 0;
        for (int k = TAPS - 1; k > 0; k--) begin
            tap_line[ch][k] = tap_line[ch][k-1];
        end
        tap_line[ch][0] = x;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(TAP_WEIGHT[k]) * longint'(tap_line[ch][k]);
        end
        rounded = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (rounded > SAMPLE_MAX) begin
            rounded = SAMPLE_MAX;
        end
        if (rounded < SAMPLE_MIN) begin
            rounded = SAMPLE_MIN;
        end
        return rounded[SBITS-1:0];
    endfunction

    // Favour the rails and silence, otherwise any value
    function automatic t_sample pick_level();
        t_sample v;
        case ($urandom_range(0, 4))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = '0;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Send one sample pair. Idle for a drawn number of cycles first (valid low),
    // then hold valid and payload until the transfer, and queue what it should give.
    task automatic push_sample(input t_sample red, input t_sample ir, input bit known,
                               input t_filtered_pair typed_pair);
        int gap;
        t_filtered_pair predicted;
        gap = idle_on ? int'($urandom_range(0, 13)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sample_red <= red;
        i_sample_ir  <= ir;
        do @(posedge i_clk); while (!o_ready);
        predicted.red = lowpass_step(0, red);
        predicted.ir  = lowpass_step(1, ir);
        pending_filtered.push_back(known ? typed_pair : predicted);
    endtask

    // Drop valid, then wait until every queued result has come back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_filtered.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Stimulus: opening table, then random segments shaped like real signals
    initial begin : stimulus
        int sent;
        int next_pause;
        int len;
        int period;
        t_seg_kind kind;
        t_sample base_red, base_ir, alt_red, alt_ir;
        t_sample red_now, ir_now;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample_red = '0;
        i_sample_ir  = '0;
        foreach (tap_line[c, k]) begin
            tap_line[c][k] = '0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < PLAN_ROWS; row++) begin
            for (int rep = 0; rep < OPENING_PLAN[row].reps; rep++) begin
                push_sample(OPENING_PLAN[row].red, OPENING_PLAN[row].ir,
                            OPENING_PLAN[row].known && (rep == OPENING_PLAN[row].reps - 1),
                            OPENING_PLAN[row].want);
            end
        end

        // Hold off until the filter has delivered everything so far
        wait_for_drain();

        sent       = 0;
        next_pause = PAUSE_EVERY;
        while (sent < RANDOM_ITEMS) begin
            kind     = t_seg_kind'($urandom_range(0, 4));
            idle_on  = ($urandom_range(0, 3) != 0);
            base_red = pick_level();
            base_ir  = pick_level();
            alt_red  = pick_level();
            alt_ir   = pick_level();
            period   = $urandom_range(1, 8);
            case (kind)
                SEG_NOISE:   len = $urandom_range(1, 40);
                SEG_HOLD:    len = $urandom_range(1, 60);
                SEG_IMPULSE: len = $urandom_range(1, 56);
                SEG_WOBBLE:  len = $urandom_range(4, 40);
                default:     len = $urandom_range(8, 60);
            endcase
            for (int k = 0; k < len; k++) begin
                case (kind)
                    SEG_NOISE: begin
                        red_now = 16'($urandom);
                        ir_now  = 16'($urandom);
                    end
                    SEG_HOLD: begin
                        red_now = base_red;
                        ir_now  = base_ir;
                    end
                    SEG_IMPULSE: begin
                        red_now = (k == 0) ? base_red : t_sample'(0);
                        ir_now  = (k == 0) ? base_ir  : t_sample'(0);
                    end
                    SEG_WOBBLE: begin
                        // small swing around a level; wrap past the rails is allowed
                        red_now = base_red + 16'($urandom_range(0, 511)) - 16'd256;
                        ir_now  = base_ir  + 16'($urandom_range(0, 511)) - 16'd256;
                    end
                    default: begin
                        red_now = ((k / period) % 2) ? alt_red : base_red;
                        ir_now  = ((k / period) % 2) ? alt_ir  : base_ir;
                    end
                endcase
                push_sample(red_now, ir_now, 1'b0, '0);
                sent++;
            end
            if (sent >= next_pause) begin
                wait_for_drain();
                next_pause += PAUSE_EVERY;
            end
        end

        // Drain, then watch a while longer for anything stray
        wait_for_drain();
        repeat (TAPS + 16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_dual_channel_fir_lowpass: done, clean");
        end else begin
            $display("tb_dual_channel_fir_lowpass: done, errors");
        end
        $finish;
    end

    // Result side: stall for a drawn number of cycles once a result is offered,
    // then take it and compare with the oldest pending pair.
    initial begin : result_sink
        int stall;
        t_filtered_pair want;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? int'($urandom_range(0, 13)) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                do @(posedge i_clk); while (!o_valid);
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_filtered.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, red %0d ir %0d",
                         $time, o_filtered_red, o_filtered_ir);
            end else begin
                want = pending_filtered.pop_front();
                if (o_filtered_red !== want.red) begin
                    mismatch_count++;
                    $display("%0t: filtered_red expected %0d got %0d",
                             $time, want.red, o_filtered_red);
                end
                if (o_filtered_ir !== want.ir) begin
                    mismatch_count++;
                    $display("%0t: filtered_ir expected %0d got %0d",
                             $time, want.ir, o_filtered_ir);
                end
            end
        end
    end

    // Drop out if the run hangs
    initial begin : watchdog
        #4_000_000;
        $display("tb_dual_channel_fir_lowpass: done, errors");
        $finish;
    end

endmodule
